// ===== hdl/qte_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qte_pkg
// Shared constants, types and the arctangent table for the quaternion to
// Euler angle converter.
// ----------------------------------------------------------------------------
package qte_pkg;

    localparam int FRAC_BITS_DEF     = 14;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam int IN_W    = 16;   // width of one quaternion component
    localparam int OUT_W   = 16;   // width of roll and yaw
    localparam int PITCH_W = 15;   // width of pitch
    localparam int ANG_W   = 26;   // internal angle, degrees with 16 fraction bits
    localparam int CW      = 33;   // CORDIC x and y width
    localparam int NORM_W  = 30;   // operands are normalized below 2^30
    localparam int SQ_IN_W = 61;   // radicand of the pitch cosine
    localparam int SQ_N    = 31;   // root bits, one per pipeline stage

    localparam logic signed [ANG_W-1:0] ANG_90  = ANG_W'(5898240);
    localparam logic signed [ANG_W-1:0] ANG_180 = ANG_W'(11796480);
    localparam logic signed [PITCH_W-1:0] PITCH_LIM = PITCH_W'(11520);

    typedef struct packed {
        logic zero;
        logic xneg;
        logic yneg;
    } t_aflags;

    // atan(2^-i) in degrees with 16 fraction bits
    function automatic logic signed [ANG_W-1:0] atan_deg(input int unsigned idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            0:  v = ANG_W'(2949120);
            1:  v = ANG_W'(1740967);
            2:  v = ANG_W'(919879);
            3:  v = ANG_W'(466945);
            4:  v = ANG_W'(234379);
            5:  v = ANG_W'(117304);
            6:  v = ANG_W'(58666);
            7:  v = ANG_W'(29335);
            8:  v = ANG_W'(14668);
            9:  v = ANG_W'(7334);
            10: v = ANG_W'(3667);
            11: v = ANG_W'(1833);
            12: v = ANG_W'(917);
            13: v = ANG_W'(458);
            14: v = ANG_W'(229);
            15: v = ANG_W'(115);
            16: v = ANG_W'(57);
            17: v = ANG_W'(29);
            18: v = ANG_W'(14);
            19: v = ANG_W'(7);
            20: v = ANG_W'(4);
            21: v = ANG_W'(2);
            22: v = ANG_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/qte_isqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qte_isqrt
// Pipelined integer square root, one root bit per stage, floor result.
// ----------------------------------------------------------------------------
module qte_isqrt (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic [qte_pkg::SQ_IN_W-1:0] i_v,
    output logic      [qte_pkg::SQ_N-1:0]    o_root
);
    localparam int N  = qte_pkg::SQ_N;
    localparam int RW = qte_pkg::SQ_IN_W + 2;

    logic [RW-1:0] r_rem [0:N-1];
    logic [N-1:0]  r_q   [0:N-1];

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_stage
            localparam int B = N - 1 - g;
            logic [RW-1:0] rem_in;
            logic [N-1:0]  q_in;
            logic [RW-1:0] trial;
            if (g == 0) begin : g_first
                assign rem_in = RW'(i_v);
                assign q_in   = '0;
            end else begin : g_next
                assign rem_in = r_rem[g-1];
                assign q_in   = r_q[g-1];
            end
            // (q + 2^B)^2 - q^2 with q holding only bits above B
            assign trial = (RW'(q_in) << (B + 1)) + (RW'(1) << (2 * B));
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (rem_in >= trial) begin
                        r_rem[g] <= rem_in - trial;
                        r_q[g]   <= q_in | (N'(1) << B);
                    end else begin
                        r_rem[g] <= rem_in;
                        r_q[g]   <= q_in;
                    end
                end
            end
        end
    endgenerate

    assign o_root = r_q[N-1];
endmodule
`default_nettype wire

// ===== hdl/qte_cordic.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qte_cordic
// Pipelined atan2 in degrees: normalize, vectoring CORDIC, quadrant fix-up
// and rounding to 1/128 degree.
// ----------------------------------------------------------------------------
module qte_cordic #(
    parameter int IW     = 35,
    parameter int STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_en,
    input  wire logic signed [IW-1:0]            i_y,
    input  wire logic signed [IW-1:0]            i_x,
    output logic signed [qte_pkg::OUT_W-1:0]     o_angle
);
    localparam int PW = $clog2(IW);
    localparam int CW = qte_pkg::CW;
    localparam int ZW = qte_pkg::ANG_W;
    localparam logic [PW-1:0] TOP = PW'(qte_pkg::NORM_W - 1);

    // Magnitudes and leading-one position
    logic [IW-1:0]    n_ax, n_ay, m;
    logic [PW-1:0]    n_p;
    logic [IW-1:0]    r_ax, r_ay;
    logic [PW-1:0]    r_p;
    qte_pkg::t_aflags r_fa;

    assign n_ax = i_x[IW-1] ? (~i_x + 1'b1) : i_x;
    assign n_ay = i_y[IW-1] ? (~i_y + 1'b1) : i_y;
    assign m    = n_ax | n_ay;

    always_comb begin
        n_p = '0;
        for (int k = 0; k < IW; k++) begin
            if (m[k]) n_p = PW'(k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax      <= n_ax;
            r_ay      <= n_ay;
            r_p       <= n_p;
            r_fa.zero <= (m == '0);
            r_fa.xneg <= i_x[IW-1];
            r_fa.yneg <= i_y[IW-1];
        end
    end

    // Shift so the larger magnitude has its top bit at position 29
    logic [IW-1:0] sx, sy;
    always_comb begin
        if (r_p > TOP) begin
            sx = r_ax >> (r_p - TOP);
            sy = r_ay >> (r_p - TOP);
        end else begin
            sx = r_ax << (TOP - r_p);
            sy = r_ay << (TOP - r_p);
        end
    end

    logic signed [CW-1:0] r_cx [0:STAGES];
    logic signed [CW-1:0] r_cy [0:STAGES];
    logic signed [ZW-1:0] r_z  [0:STAGES];
    qte_pkg::t_aflags     r_f  [0:STAGES];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cx[0] <= CW'(sx[qte_pkg::NORM_W-1:0]);
            r_cy[0] <= CW'(sy[qte_pkg::NORM_W-1:0]);
            r_z[0]  <= '0;
            r_f[0]  <= r_fa;
        end
    end

    genvar g;
    generate
        for (g = 0; g < STAGES; g++) begin : g_rot
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (r_cy[g] >= 0) begin
                        r_cx[g+1] <= r_cx[g] + (r_cy[g] >>> g);
                        r_cy[g+1] <= r_cy[g] - (r_cx[g] >>> g);
                        r_z[g+1]  <= r_z[g] + qte_pkg::atan_deg(g);
                    end else begin
                        r_cx[g+1] <= r_cx[g] - (r_cy[g] >>> g);
                        r_cy[g+1] <= r_cy[g] + (r_cx[g] >>> g);
                        r_z[g+1]  <= r_z[g] - qte_pkg::atan_deg(g);
                    end
                    r_f[g+1] <= r_f[g];
                end
            end
        end
    endgenerate

    // Clamp to the first quadrant, mirror, then round half up
    logic signed [ZW-1:0] zc, zq, zr;
    qte_pkg::t_aflags     ff;
    assign ff = r_f[STAGES];
    always_comb begin
        zc = r_z[STAGES];
        if (zc < 0) zc = '0;
        if (zc > qte_pkg::ANG_90) zc = qte_pkg::ANG_90;
        zq = ff.xneg ? (qte_pkg::ANG_180 - zc) : zc;
        if (ff.yneg) zq = -zq;
        if (ff.zero) zq = '0;
        zr = (zq + ZW'(256)) >>> 9;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) o_angle <= zr[qte_pkg::OUT_W-1:0];
    end
endmodule
`default_nettype wire

// ===== hdl/quaternion_to_euler_angles.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Converts a Q1.14 quaternion to roll, pitch and yaw (ZYX) in 1/128 degree.
//
// Input words arrive on the s_axis channel: tdata holds x, y, z, w, 16 bits
// each, x in the lowest bits. Results leave on the m_axis channel: tdata holds
// roll (16), pitch (15) and yaw (16) from bit 0 up, tuser carries the pitch
// clamp flag. One word is accepted per cycle when tready is high.
// Latency is FRAC-independent and set by the pitch path: the product, term,
// rescale and radicand stages, the 31-stage square root and the pitch CORDIC.
// Throughput is one word per cycle. The whole pipeline advances together;
// when the receiver holds m_axis_tready low with a word waiting, every stage
// holds, s_axis_tready drops, and nothing is lost or repeated.
// Reset (synchronous, active low) clears all valid bits and holds
// s_axis_tready low; data registers are not reset.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles #(
    parameter int FRAC_BITS     = qte_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [63:0] i_s_axis_tdata,   // quat_x, quat_y, quat_z, quat_w
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [47:0]      o_m_axis_tdata,   // roll_deg, pitch_deg, yaw_deg, pad
    output logic             o_m_axis_tuser    // pitch_clamped
);
    localparam int SW   = ((2 * FRAC_BITS > 33) ? 2 * FRAC_BITS : 33) + 2;
    localparam int PW   = 32;
    localparam int N    = qte_pkg::SQ_N;
    localparam int LAT  = CORDIC_STAGES + 3;
    localparam int L    = 4 + N + LAT;
    localparam int RYD  = 2 + N;        // roll and yaw operand delay
    localparam int PYD  = 1 + N;        // pitch sine delay
    localparam int CLD  = 1 + N + LAT;  // clamp flag delay
    localparam int RSH  = (2 * FRAC_BITS >= 30) ? 2 * FRAC_BITS - 30 : 0;
    localparam int LSH  = (2 * FRAC_BITS < 30) ? 30 - 2 * FRAC_BITS : 0;
    localparam int NW   = qte_pkg::NORM_W;

    logic         en;
    logic [L-1:0] r_vld;

    assign en              = !r_vld[L-1] || i_m_axis_tready;
    assign o_s_axis_tready = en && i_rst_n;
    assign o_m_axis_tvalid = r_vld[L-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[L-2:0], i_s_axis_tvalid};
        end
    end

    // Stage 1: products
    logic signed [15:0] qx, qy, qz, qw;
    assign qx = i_s_axis_tdata[15:0];
    assign qy = i_s_axis_tdata[31:16];
    assign qz = i_s_axis_tdata[47:32];
    assign qw = i_s_axis_tdata[63:48];

    logic signed [31:0] r_wx, r_yz, r_xx, r_yy, r_wy, r_zx, r_wz, r_xy, r_zz;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wx <= qw * qx;
            r_yz <= qy * qz;
            r_xx <= qx * qx;
            r_yy <= qy * qy;
            r_wy <= qw * qy;
            r_zx <= qz * qx;
            r_wz <= qw * qz;
            r_xy <= qx * qy;
            r_zz <= qz * qz;
        end
    end

    // Stage 2: sine and cosine terms
    localparam logic signed [SW-1:0] ONE = SW'(1) << (2 * FRAC_BITS);
    logic signed [SW-1:0] r_sinr, r_cosr, r_sinp, r_siny, r_cosy;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sinr <= (SW'(r_wx) + SW'(r_yz)) <<< 1;
            r_cosr <= ONE - ((SW'(r_xx) + SW'(r_yy)) <<< 1);
            r_sinp <= (SW'(r_wy) - SW'(r_zx)) <<< 1;
            r_siny <= (SW'(r_wz) + SW'(r_xy)) <<< 1;
            r_cosy <= ONE - ((SW'(r_yy) + SW'(r_zz)) <<< 1);
        end
    end

    // Stage 3: pitch sine magnitude rescaled to 30 fraction bits
    logic [SW-1:0]   ms, s30w;
    logic [NW-1:0]   r_s30;
    logic            r_clp, r_pos, r_sneg;
    assign ms   = r_sinp[SW-1] ? (~r_sinp + 1'b1) : r_sinp;
    assign s30w = (ms >> RSH) << LSH;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s30  <= s30w[NW-1:0];
            r_clp  <= (ms >= ONE);
            r_pos  <= !r_sinp[SW-1] && (r_sinp != '0);
            r_sneg <= r_sinp[SW-1];
        end
    end

    // Stage 4: radicand 2^60 - s30^2
    logic [59:0]                   sq;
    logic [qte_pkg::SQ_IN_W-1:0]   r_rad;
    assign sq = r_s30 * r_s30;
    always_ff @(posedge i_clk) begin
        if (en) r_rad <= (qte_pkg::SQ_IN_W'(1) << 60) - qte_pkg::SQ_IN_W'(sq);
    end

    logic [N-1:0] root;
    qte_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_v    (r_rad),
        .o_root (root)
    );

    // Delay lines aligning operands with the square root output
    logic signed [SW-1:0] r_sinr_d [0:RYD-1];
    logic signed [SW-1:0] r_cosr_d [0:RYD-1];
    logic signed [SW-1:0] r_siny_d [0:RYD-1];
    logic signed [SW-1:0] r_cosy_d [0:RYD-1];
    logic signed [PW-1:0] r_ps_d   [0:PYD-1];
    logic [CLD-1:0]       r_clp_d, r_pos_d;
    logic signed [PW-1:0] ps;

    assign ps = r_sneg ? -PW'(r_s30) : PW'(r_s30);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sinr_d[0] <= r_sinr;
            r_cosr_d[0] <= r_cosr;
            r_siny_d[0] <= r_siny;
            r_cosy_d[0] <= r_cosy;
            for (int k = 1; k < RYD; k++) begin
                r_sinr_d[k] <= r_sinr_d[k-1];
                r_cosr_d[k] <= r_cosr_d[k-1];
                r_siny_d[k] <= r_siny_d[k-1];
                r_cosy_d[k] <= r_cosy_d[k-1];
            end
            r_ps_d[0] <= ps;
            for (int k = 1; k < PYD; k++) begin
                r_ps_d[k] <= r_ps_d[k-1];
            end
            r_clp_d <= {r_clp_d[CLD-2:0], r_clp};
            r_pos_d <= {r_pos_d[CLD-2:0], r_pos};
        end
    end

    logic signed [qte_pkg::OUT_W-1:0] roll, yaw, pang;

    qte_cordic #(.IW(SW), .STAGES(CORDIC_STAGES)) u_roll (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (r_sinr_d[RYD-1]),
        .i_x     (r_cosr_d[RYD-1]),
        .o_angle (roll)
    );

    qte_cordic #(.IW(SW), .STAGES(CORDIC_STAGES)) u_yaw (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (r_siny_d[RYD-1]),
        .i_x     (r_cosy_d[RYD-1]),
        .o_angle (yaw)
    );

    qte_cordic #(.IW(PW), .STAGES(CORDIC_STAGES)) u_pitch (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (r_ps_d[PYD-1]),
        .i_x     (PW'(root)),
        .o_angle (pang)
    );

    logic signed [qte_pkg::PITCH_W-1:0] pitch;
    assign pitch = r_clp_d[CLD-1]
                 ? (r_pos_d[CLD-1] ? qte_pkg::PITCH_LIM : -qte_pkg::PITCH_LIM)
                 : pang[qte_pkg::PITCH_W-1:0];

    assign o_m_axis_tdata = {1'b0, yaw, pitch, roll};
    assign o_m_axis_tuser = r_clp_d[CLD-1];

    // A clamped pitch must sit exactly at one of the poles.
    a_clamp_pole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |->
        (pitch == qte_pkg::PITCH_LIM || pitch == -qte_pkg::PITCH_LIM))
        else $error("clamped pitch is not at a pole");

    // Pitch, clamped or from the arcsine path, stays within +-90 degrees.
    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
        (pitch <= qte_pkg::PITCH_LIM && pitch >= -qte_pkg::PITCH_LIM))
        else $error("pitch out of range");

    // Roll and yaw stay within +-180 degrees.
    a_ry_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
        (roll <= 16'sd23040 && roll >= -16'sd23040 &&
         yaw <= 16'sd23040 && yaw >= -16'sd23040))
        else $error("roll or yaw out of range");

    // A stalled output word holds its angles.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        ($stable(roll) && $stable(yaw) && $stable(pitch)))
        else $error("output changed during stall");
endmodule
`default_nettype wire

// ===== dv/quaternion_to_euler_angles_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_tb
// Self-checking bench for the quaternion to Euler angle converter. Directed
// quaternions (axes, extremes, gimbal lock, zero and non-unit inputs) and
// random unit and raw quaternions are streamed in under random stalls on both
// sides, not the last 100; each output is checked by a table or bit-exact predictor.
// ----------------------------------------------------------------------------
`default_nettype none
module quaternion_to_euler_angles_tb;

    localparam int    LATENCY  = 54;
    localparam int    N_RANDOM = 900;
    localparam int    Q_ONE    = 16384;
    localparam longint ANG_SC  = 65536;

    typedef struct packed {
        logic signed [qte_pkg::OUT_W-1:0]   roll;
        logic signed [qte_pkg::PITCH_W-1:0] pitch;
        logic signed [qte_pkg::OUT_W-1:0]   yaw;
        logic                               clamped;
    } t_angles;

    typedef struct {
        logic signed [qte_pkg::IN_W-1:0] qx, qy, qz, qw;
        bit                              has_exp;
        t_angles                         exp;
    } t_quat_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [63:0] i_s_axis_tdata = '0;      // quat_x, quat_y, quat_z, quat_w
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [47:0] o_m_axis_tdata;           // roll_deg, pitch_deg, yaw_deg, pad
    logic        o_m_axis_tuser;           // pitch_clamped

    t_angles   angles_pending[$];
    t_quat_row quat_table[$];
    int        n_errors = 0;
    bit        stalls_on = 1'b1;

    quaternion_to_euler_angles DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #50ms;
        $display("FAILURE");
        $finish;
    end

    function automatic longint ashr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint unsigned sqrt_floor(longint unsigned v);
        longint unsigned res = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // Vectoring CORDIC angle of (x, y), degrees with 16 fraction bits.
    function automatic longint vector_angle(longint y, longint x);
        longint unsigned ax = (x < 0) ? -x : x;
        longint unsigned ay = (y < 0) ? -y : y;
        longint cx, cy, dx, dy, z = 0;
        if (ax == 0 && ay == 0) return 0;
        while ((ax | ay) >= (64'd1 << 30)) begin
            ax >>= 1;
            ay >>= 1;
        end
        while ((ax | ay) < (64'd1 << 29)) begin
            ax <<= 1;
            ay <<= 1;
        end
        cx = ax;
        cy = ay;
        for (int i = 0; i < qte_pkg::CORDIC_STAGES_DEF; i++) begin
            dx = ashr(cy, i);
            dy = ashr(cx, i);
            if (cy >= 0) begin
                cx += dx;
                cy -= dy;
                z += longint'(qte_pkg::atan_deg(i));
            end else begin
                cx -= dx;
                cy += dy;
                z -= longint'(qte_pkg::atan_deg(i));
            end
        end
        if (z < 0) z = 0;
        if (z > 90 * ANG_SC) z = 90 * ANG_SC;
        if (x < 0) z = 180 * ANG_SC - z;
        if (y < 0) z = -z;
        return z;
    endfunction

    function automatic longint round_deg(longint z);
        return ashr(z + 256, 9);
    endfunction

    function automatic t_angles predict_angles(longint x, longint y, longint z, longint w);
        longint one = 64'sd1 << 28;
        longint sinr = 2 * (w * x + y * z);
        longint cosr = one - 2 * (x * x + y * y);
        longint sinp = 2 * (w * y - z * x);
        longint siny = 2 * (w * z + x * y);
        longint cosy = one - 2 * (y * y + z * z);
        longint unsigned ms = (sinp < 0) ? -sinp : sinp;
        longint unsigned s30, c;
        t_angles a;
        a.roll = qte_pkg::OUT_W'(round_deg(vector_angle(sinr, cosr)));
        a.yaw  = qte_pkg::OUT_W'(round_deg(vector_angle(siny, cosy)));
        if (ms >= one) begin
            a.pitch   = (sinp > 0) ? qte_pkg::PITCH_LIM : -qte_pkg::PITCH_LIM;
            a.clamped = 1'b1;
        end else begin
            s30 = ms << 2;
            c = sqrt_floor((64'd1 << 60) - s30 * s30);
            a.pitch = qte_pkg::PITCH_W'(round_deg(vector_angle(
                (sinp < 0) ? -longint'(s30) : longint'(s30), longint'(c))));
            a.clamped = 1'b0;
        end
        return a;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        n_errors++;
    endtask

    task automatic send_quat(t_quat_row r);
        t_angles p = predict_angles(r.qx, r.qy, r.qz, r.qw);
        if (r.has_exp && p != r.exp)
            report_mismatch("predictor vs table roll", p.roll, r.exp.roll);
        if (stalls_on && $urandom_range(0, 5) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {r.qw, r.qz, r.qy, r.qx};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        angles_pending.insert(angles_pending.size(), r.has_exp ? r.exp : p);
    endtask

    function automatic t_quat_row row(int x, int y, int z, int w, bit he = 0,
                                      int r = 0, int p = 0, int yw = 0, bit c = 0);
        t_quat_row q;
        q.qx = qte_pkg::IN_W'(x);
        q.qy = qte_pkg::IN_W'(y);
        q.qz = qte_pkg::IN_W'(z);
        q.qw = qte_pkg::IN_W'(w);
        q.has_exp = he;
        q.exp = '{roll: qte_pkg::OUT_W'(r), pitch: qte_pkg::PITCH_W'(p),
                  yaw: qte_pkg::OUT_W'(yw), clamped: c};
        return q;
    endfunction

    task automatic queue_row(t_quat_row q);
        quat_table.insert(quat_table.size(), q);
    endtask

    // Output side: random ready bursts and comparison against the oldest word.
    always @(posedge i_clk) begin
        t_angles got, want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.roll    = o_m_axis_tdata[15:0];
            got.pitch   = o_m_axis_tdata[30:16];
            got.yaw     = o_m_axis_tdata[46:31];
            got.clamped = o_m_axis_tuser;
            if (angles_pending.size() == 0) begin
                report_mismatch("unexpected word", 0, 0);
            end else begin
                want = angles_pending.pop_front();
                if (got.roll != want.roll) report_mismatch("roll", got.roll, want.roll);
                if (got.pitch != want.pitch)
                    report_mismatch("pitch", got.pitch, want.pitch);
                if (got.yaw != want.yaw) report_mismatch("yaw", got.yaw, want.yaw);
                if (got.clamped != want.clamped)
                    report_mismatch("clamp", got.clamped, want.clamped);
            end
        end
    end

    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
            end else if (stalls_on && $urandom_range(0, 4) == 0) begin
                hold = $urandom_range(0, 8);
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        real ang, ax, ay, az, n;
        t_quat_row r;
        int waited;
        queue_row(row(0, 0, 0, Q_ONE, 1, 0, 0, 0, 0));          // identity
        queue_row(row(0, 0, 0, -Q_ONE, 1, 0, 0, 0, 0));
        queue_row(row(0, 0, 0, 0, 1, 0, 0, 0, 0));              // zero quaternion
        queue_row(row(Q_ONE, 0, 0, 0, 1, 23040, 0, 0, 0));      // roll 180, negative cos
        queue_row(row(0, 0, Q_ONE, 0, 1, 0, 0, 23040, 0));
        queue_row(row(0, Q_ONE, 0, 0, 1, 23040, 0, 23040, 0));
        // Gimbal lock: just below the pole, then clamped to plus or minus 90, both signs.
        queue_row(row(0, 11585, 0, 11585, 0));
        queue_row(row(0, 11586, 0, 11586, 1, 23040, 11520, 23040, 1));
        queue_row(row(0, -11586, 0, 11586, 1, 23040, -11520, 23040, 1));
        queue_row(row(11586, 0, 0, 11586));
        queue_row(row(0, 0, 11586, 11586));
        queue_row(row(-16384, -16384, -16384, -16384));
        queue_row(row(16384, 16384, 16384, 16384));
        queue_row(row(-32768, 32767, -32768, 32767));          // raw extremes
        queue_row(row(32767, -32768, 32767, -32768));
        queue_row(row(-1, -1, -1, -1));
        queue_row(row(1, 1, 1, 1));
        queue_row(row(0, 0, 0, 1));
        queue_row(row(5000, -3000, 8000, 12000));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (quat_table[k]) send_quat(quat_table[k]);

        for (int k = 0; k < N_RANDOM; k++) begin
            if (k == N_RANDOM - 100) stalls_on = 1'b0;
            if ($urandom_range(0, 3) == 0) begin
                r = row($urandom, $urandom, $urandom, $urandom);
            end else begin
                // Mostly unit quaternions from a random axis and angle.
                ax = $urandom_range(0, 2000) - 1000.0;
                ay = $urandom_range(0, 2000) - 1000.0;
                az = $urandom_range(0, 2000) - 1000.0;
                n = $sqrt(ax * ax + ay * ay + az * az) + 1e-9;
                ang = ($urandom_range(0, 100000) / 100000.0) * 6.2831853;
                r = row($rtoi(Q_ONE * $sin(ang / 2) * ax / n),
                        $rtoi(Q_ONE * $sin(ang / 2) * ay / n),
                        $rtoi(Q_ONE * $sin(ang / 2) * az / n),
                        $rtoi(Q_ONE * $cos(ang / 2)));
            end
            send_quat(r);
        end
        i_s_axis_tvalid <= 1'b0;

        waited = 0;
        while (angles_pending.size() != 0 && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (LATENCY + 10) @(posedge i_clk);
        if (n_errors == 0 && angles_pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/qte_pkg.sv
hdl/qte_isqrt.sv
hdl/qte_cordic.sv
hdl/quaternion_to_euler_angles.sv
dv/quaternion_to_euler_angles_tb.sv
